[design/inactivity_sleep_controller_defines.svh]
// Assertion macros used by the top-level file to check its own logic.
`ifndef INACTIVITY_SLEEP_CONTROLLER_DEFINES_SVH
`define INACTIVITY_SLEEP_CONTROLLER_DEFINES_SVH

// A property that must hold in the same cycle as its condition.
`define ISC_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// A property that must hold in the cycle after its condition.
`define ISC_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[design/isc_pkg.sv]
package isc_pkg;

    localparam int HISTORY_DEPTH_DEF = 8;

    localparam int TIME_W    = 32;
    localparam int ACCEL_W   = 16;
    localparam int HEART_W   = 8;
    localparam int SQ_W      = 32;
    localparam int MAG_SUM_W = SQ_W + 2;
    localparam int FLAGS_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_W-1:0]   MOTION_THR_RST = 32'd1048576;
    localparam logic [TIME_W-1:0]  CAUTIOUS_RST   = 32'd300000;
    localparam logic [TIME_W-1:0]  DEEP_RST       = 32'd1200000;
    localparam logic [HEART_W-1:0] HEART_HIGH_RST = 8'd150;
    localparam logic [HEART_W-1:0] HEART_LOW_RST  = 8'd40;
    localparam logic [TIME_W-1:0]  PERIOD_RST     = 32'd5000;

    // Bit positions of a history entry's flags.
    localparam int FLAG_FALL_BIT   = 0;
    localparam int FLAG_STRESS_BIT = 1;
    localparam int FLAG_EMERG_BIT  = 2;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_CAUTIOUS = 2'd1,
        MODE_DEEP     = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REQ_NONE      = 2'd0,
        REQ_LOW_POWER = 2'd1,
        REQ_NORMAL    = 2'd2
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTION_THR = 3'd0,
        CFG_CAUTIOUS   = 3'd1,
        CFG_DEEP       = 3'd2,
        CFG_HEART_HIGH = 3'd3,
        CFG_HEART_LOW  = 3'd4,
        CFG_PERIOD     = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_UPDATE,
        ST_DECIDE
    } state_t;

    // Input item, last field in the lowest bits.
    typedef struct packed {
        logic [4:0]                pad;
        logic                      emergency;
        logic                      high_stress;
        logic                      fall_alert;
        logic [HEART_W-1:0]        heart_bpm;
        logic signed [ACCEL_W-1:0] accel_z;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_x;
        logic [TIME_W-1:0]         now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0] pad;
        logic       history_recorded;
        logic       motion_seen;
        req_t       mode_request;
        mode_t      sleep_mode;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic square;
        logic sum;
        logic update;
        logic decide;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

[design/isc_ctrl.sv]
module isc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  isc_pkg::status_t status,
    output isc_pkg::cmd_t    cmd
);
    import isc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // The result waits here until the output register can take it.
                if (status.out_free)
                begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/isc_datapath.sv]
module isc_datapath #(
    parameter int HISTORY_DEPTH = isc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [isc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [isc_pkg::CFG_W-1:0]         cfg_data,
    input  isc_pkg::in_item_t                 in_item,
    input  isc_pkg::cmd_t                     cmd,
    output isc_pkg::status_t                  status,
    output isc_pkg::out_item_t                out_item,
    output logic                              out_valid,
    input  logic                              out_ready
);
    import isc_pkg::*;

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    function automatic logic [ACCEL_W-1:0] axis_mag(input logic signed [ACCEL_W-1:0] a);
        logic [ACCEL_W-1:0] neg;
        begin
            neg = ACCEL_W'(-a);
            return a[ACCEL_W-1] ? neg : ACCEL_W'(a);
        end
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0]   motion_thr_reg;
    logic [TIME_W-1:0]  cautious_reg;
    logic [TIME_W-1:0]  deep_reg;
    logic [HEART_W-1:0] heart_high_reg;
    logic [HEART_W-1:0] heart_low_reg;
    logic [TIME_W-1:0]  period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_thr_reg <= MOTION_THR_RST;
            cautious_reg   <= CAUTIOUS_RST;
            deep_reg       <= DEEP_RST;
            heart_high_reg <= HEART_HIGH_RST;
            heart_low_reg  <= HEART_LOW_RST;
            period_reg     <= PERIOD_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MOTION_THR: motion_thr_reg <= cfg_data;
                CFG_CAUTIOUS:   cautious_reg   <= cfg_data;
                CFG_DEEP:       deep_reg       <= cfg_data;
                CFG_HEART_HIGH: heart_high_reg <= cfg_data[HEART_W-1:0];
                CFG_HEART_LOW:  heart_low_reg  <= cfg_data[HEART_W-1:0];
                CFG_PERIOD:     period_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Block state.
    mode_t             mode_reg;
    req_t              req_reg;
    logic [TIME_W-1:0] last_motion_reg;
    logic [TIME_W-1:0] last_record_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [FLAGS_W-1:0] ring_flags_reg [HISTORY_DEPTH];
    logic [HEART_W-1:0] ring_heart_reg [HISTORY_DEPTH];
    logic [FLAGS_W-1:0] item_flags;

    // Item and intermediate registers.
    in_item_t         item_reg;
    logic [SQ_W-1:0]  sq_x_reg;
    logic [SQ_W-1:0]  sq_y_reg;
    logic [SQ_W-1:0]  sq_z_reg;
    logic             motion_reg;
    logic             record_reg;
    logic [MAG_SUM_W-1:0] mag_sum;
    logic [ACCEL_W-1:0]   mag_x;
    logic [ACCEL_W-1:0]   mag_y;
    logic [ACCEL_W-1:0]   mag_z;

    assign mag_x   = axis_mag(item_reg.accel_x);
    assign mag_y   = axis_mag(item_reg.accel_y);
    assign mag_z   = axis_mag(item_reg.accel_z);
    assign mag_sum = MAG_SUM_W'(sq_x_reg) + MAG_SUM_W'(sq_y_reg) + MAG_SUM_W'(sq_z_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (cmd.square)
        begin
            sq_x_reg <= SQ_W'(mag_x) * SQ_W'(mag_x);
            sq_y_reg <= SQ_W'(mag_y) * SQ_W'(mag_y);
            sq_z_reg <= SQ_W'(mag_z) * SQ_W'(mag_z);
        end
        if (cmd.sum)
        begin
            motion_reg <= mag_sum > MAG_SUM_W'(motion_thr_reg);
            record_reg <= (item_reg.now_ms - last_record_reg) > period_reg;
        end
    end

    assign item_flags[FLAG_FALL_BIT]   = item_reg.fall_alert;
    assign item_flags[FLAG_STRESS_BIT] = item_reg.high_stress;
    assign item_flags[FLAG_EMERG_BIT]  = item_reg.emergency;

    // Decision logic on the state after the update.
    logic [HISTORY_DEPTH-1:0] entry_bad;
    logic                     history_clear;
    logic [TIME_W-1:0]        idle_ms;
    mode_t                    mode_mid;
    mode_t                    mode_final;
    req_t                     req_final;

    always_comb
    begin
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            entry_bad[i] = (|ring_flags_reg[i])
                || (ring_heart_reg[i] > heart_high_reg)
                || ((ring_heart_reg[i] != '0) && (ring_heart_reg[i] < heart_low_reg));
        end
    end

    assign history_clear = ~|entry_bad;
    assign idle_ms       = item_reg.now_ms - last_motion_reg;

    always_comb
    begin
        mode_mid  = mode_reg;
        req_final = req_reg;
        if ((idle_ms > cautious_reg) && (mode_reg == MODE_NONE) && history_clear)
        begin
            mode_mid  = MODE_CAUTIOUS;
            req_final = REQ_LOW_POWER;
        end
        mode_final = mode_mid;
        if ((idle_ms > deep_reg) && (mode_mid == MODE_CAUTIOUS) && history_clear)
        begin
            mode_final = MODE_DEEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_NONE;
            req_reg         <= REQ_NONE;
            last_motion_reg <= '0;
            last_record_reg <= '0;
            ptr_reg         <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                ring_flags_reg[i] <= '0;
                ring_heart_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.update)
            begin
                req_reg <= REQ_NONE;
                if (motion_reg)
                begin
                    last_motion_reg <= item_reg.now_ms;
                    if (mode_reg != MODE_NONE)
                    begin
                        mode_reg <= MODE_NONE;
                        req_reg  <= REQ_NORMAL;
                    end
                end
                if (record_reg)
                begin
                    ring_flags_reg[ptr_reg] <= item_flags;
                    ring_heart_reg[ptr_reg] <= item_reg.heart_bpm;
                    last_record_reg         <= item_reg.now_ms;
                    ptr_reg <= (ptr_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                end
            end
            if (cmd.decide)
            begin
                mode_reg <= mode_final;
            end
        end
    end

    // Output register: holds one result until its transfer completes.
    logic      out_valid_reg;
    out_item_t out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            out_item_reg.pad              <= '0;
            out_item_reg.history_recorded <= record_reg;
            out_item_reg.motion_seen      <= motion_reg;
            out_item_reg.mode_request     <= req_final;
            out_item_reg.sleep_mode       <= mode_final;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;

endmodule

[design/inactivity_sleep_controller.sv]
// Inactivity sleep controller. One update is taken at a time and its single
// result leaves after these steps in order: the input accept, then the axis
// squaring, the magnitude sum and threshold compare, the state and history
// update, and the sleep decision, which the controller steps through in this
// fixed order. The decision stage waits while the output register still
// holds a result that has not been taken, and a new input is taken only
// once the decision is out. Reset clears the whole history ring at once,
// so the block is ready straight after it.
// Configuration writes take effect at once and are meant for idle periods.
`include "inactivity_sleep_controller_defines.svh"

module inactivity_sleep_controller #(
    parameter int HISTORY_DEPTH = isc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [isc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [isc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms[31:0], accel_x[47:32], accel_y[63:48], accel_z[79:64],
    // heart_bpm[87:80], fall_alert[88], high_stress[89], emergency[90]
    input  logic [isc_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sleep_mode[1:0], mode_request[3:2], motion_seen[4], history_recorded[5]
    output logic [isc_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import isc_pkg::*;

    cmd_t      cmd;
    status_t   status;
    out_item_t out_item;

    isc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    isc_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item_t'(s_tdata)),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tdata = OUT_DATA_W'(out_item);

    `ISC_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready,
        "input taken while an update is still in progress")
    `ISC_ASSERT_NOW(a_mode_legal, m_tvalid, out_item.sleep_mode != 2'd3,
        "sleep mode holds an unused code")
    `ISC_ASSERT_NOW(a_low_power_sleeps, m_tvalid && out_item.mode_request == REQ_LOW_POWER,
        out_item.sleep_mode != MODE_NONE && !out_item.motion_seen,
        "low-power request without entering sleep")
    `ISC_ASSERT_NOW(a_wake_on_motion, m_tvalid && out_item.mode_request == REQ_NORMAL,
        out_item.sleep_mode == MODE_NONE && out_item.motion_seen,
        "normal-mode request without motion wake-up")

endmodule
